// ===== hw/rtl/trt_pkg.sv =====
// Shared types and constants of the task registry table.
// Used by the channel interfaces, the sequencer, the output register and the top level.
`default_nettype none

package trt_pkg;

  // Table size; the slot RAM, the valid bits and the scan counter follow from it.
  localparam int TABLE_SLOTS = 32;
  // A listing reports at most this many matches.
  localparam int MAX_RESULTS = 32;

  localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int SCAN_W = $clog2(TABLE_SLOTS + 1);

  localparam int OPC_W  = 3;
  localparam int TASK_W = 32;
  localparam int SOCK_W = 16;
  localparam int PORT_W = 16;
  localparam int STAT_W = 3;
  localparam int REFS_W = 2;
  localparam int CNT_W  = 7;

  localparam logic [REFS_W-1:0] REFS_WITH_MSGS = 2'd2;
  localparam logic [REFS_W-1:0] REFS_PLAIN     = 2'd1;

  typedef enum logic [OPC_W-1:0] {
    OP_REGISTER  = 3'd0,
    OP_REMOVE    = 3'd1,
    OP_FIND      = 3'd2,
    OP_FIND_ANY  = 3'd3,
    OP_MARK_LOST = 3'd4,
    OP_LIST      = 3'd5
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_LOST      = 3'd2,
    ST_FULL      = 3'd3,
    ST_DUP       = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  // One stored table entry, as held in the slot RAM.
  typedef struct packed {
    logic [TASK_W-1:0] task_id;
    logic [SOCK_W-1:0] socket;
    logic [PORT_W-1:0] port;
    logic              lost;
    logic              eof;
    logic [REFS_W-1:0] refs;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // One result word.
  typedef struct packed {
    status_t           status;
    logic [TASK_W-1:0] found_task;
    logic [SOCK_W-1:0] found_socket;
    logic [PORT_W-1:0] found_port;
    logic              found_lost;
    logic              found_eof;
    logic [REFS_W-1:0] found_refs;
    logic [CNT_W-1:0]  match_count;
    logic              last;
  } result_t;

  // Slot RAM access requested by the sequencer.
  typedef struct packed {
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    entry_t            wr_data;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
  } ram_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/trt_in_if.sv =====
// Request channel of the task registry table: valid/ready and one operation word.
// Field widths come from trt_pkg.
`default_nettype none

interface trt_in_if;
  logic                       valid;
  logic                       ready;
  logic [trt_pkg::OPC_W-1:0]  opcode;
  logic [trt_pkg::TASK_W-1:0] task_id;
  logic [trt_pkg::SOCK_W-1:0] socket;
  logic [trt_pkg::PORT_W-1:0] port;
  logic                       with_messages;

  modport source (output valid, output opcode, output task_id, output socket,
                  output port, output with_messages, input ready);
  modport sink   (input valid, input opcode, input task_id, input socket,
                  input port, input with_messages, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/trt_out_if.sv =====
// Result channel of the task registry table: valid/ready and one result word.
// Field widths come from trt_pkg.
`default_nettype none

interface trt_out_if;
  logic                       valid;
  logic                       ready;
  logic [trt_pkg::STAT_W-1:0] status;
  logic [trt_pkg::TASK_W-1:0] found_task;
  logic [trt_pkg::SOCK_W-1:0] found_socket;
  logic [trt_pkg::PORT_W-1:0] found_port;
  logic                       found_lost;
  logic                       found_eof;
  logic [trt_pkg::REFS_W-1:0] found_refs;
  logic [trt_pkg::CNT_W-1:0]  match_count;
  logic                       last;

  modport source (output valid, output status, output found_task, output found_socket,
                  output found_port, output found_lost, output found_eof,
                  output found_refs, output match_count, output last, input ready);
  modport sink   (input valid, input status, input found_task, input found_socket,
                  input found_port, input found_lost, input found_eof,
                  input found_refs, input match_count, input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/task_registry_table.sv =====
// Task registry table: a fixed table of task entries keyed by task id, with a
// reference count per entry. Depends on trt_pkg, the two channel interfaces,
// trt_slot_ram, trt_seq and trt_out_reg.
//
// The request channel (req) carries one operation word: register, remove, find,
// find ignoring the connection, mark every entry on a socket as lost, or list the
// entries on a socket not marked lost. The result channel (rsp) returns one word
// for every operation, except a listing, which returns one word per match (at
// most MAX_RESULTS) and flags the final one with last. Unused opcodes give no word.
//
// Each operation walks the slot RAM in slot order, one slot per cycle while no
// listing stall holds it, through a single shared key comparator; the RAM's
// registered read port sets the pace. A full walk presents its closing word and
// then returns to idle for the next operation; a duplicate register, or a remove
// or find that hits, stops at that slot and finishes sooner. req.ready is high
// only while idle.
//
// Reset clears all valid bits, so the table is empty; entry contents are not
// cleared, and an unwritten slot is read but never used. Results wait in an
// output register; while the receiver stalls, a listing pauses on its next
// match and a closing word waits, without losing or repeating a word.
`default_nettype none

module task_registry_table (
  input  logic      clk,
  input  logic      rst,
  trt_in_if.sink    req,
  trt_out_if.source rsp
);
  import trt_pkg::*;

  ram_req_t ram;
  entry_t   rd_entry;
  logic     out_load;
  result_t  out_data;
  logic     out_free;

  // Entry storage: one write and one registered read per cycle.
  trt_slot_ram #(
    .WIDTH  (ENTRY_W),
    .DEPTH  (TABLE_SLOTS),
    .ADDR_W (SLOT_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram.wr_en),
    .wr_addr (ram.wr_addr),
    .wr_data (ram.wr_data),
    .rd_en   (ram.rd_en),
    .rd_addr (ram.rd_addr),
    .rd_data (rd_entry)
  );

  // Walks the slots and decides every operation.
  trt_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .ram      (ram),
    .rd_entry (rd_entry),
    .out_load (out_load),
    .out_data (out_data),
    .out_free (out_free)
  );

  // Holds a result word until the receiver takes it.
  trt_out_reg u_out (
    .clk  (clk),
    .rst  (rst),
    .load (out_load),
    .data (out_data),
    .free (out_free),
    .rsp  (rsp)
  );

  // After an operation is accepted, the block is busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("ready stayed high after an operation was accepted");

  // Once the block is ready again, only a closing word may still wait.
  a_ready_only_final: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !(rsp.valid && !rsp.last))
    else $error("block ready while a listing word is still pending");

  // A refused operation gives a single closing word with no count.
  a_error_single: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status != ST_OK) |-> rsp.last && (rsp.match_count == '0))
    else $error("error status on a word that is not a lone closing word");

endmodule

`default_nettype wire

// ===== hw/rtl/trt_slot_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Holds the table entries; has no dependencies.
`default_nettype none

module trt_slot_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/trt_out_reg.sv =====
// Output register of the task registry table: holds one result word for the sink.
// Depends on trt_pkg and trt_out_if.
`default_nettype none

module trt_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  trt_pkg::result_t data,
  output logic             free,
  trt_out_if.source        rsp
);
  import trt_pkg::*;

  logic    vld;
  result_t q;

  // The register can take a new word when empty or when its word leaves now.
  assign free = !vld || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (load) begin
      vld <= 1'b1;
    end else if (rsp.ready) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= data;
    end
  end

  assign rsp.valid        = vld;
  assign rsp.status       = q.status;
  assign rsp.found_task   = q.found_task;
  assign rsp.found_socket = q.found_socket;
  assign rsp.found_port   = q.found_port;
  assign rsp.found_lost   = q.found_lost;
  assign rsp.found_eof    = q.found_eof;
  assign rsp.found_refs   = q.found_refs;
  assign rsp.match_count  = q.match_count;
  assign rsp.last         = q.last;

endmodule

`default_nettype wire

// ===== hw/rtl/trt_seq.sv =====
// Sequencer of the task registry table: walks the slot RAM one slot a cycle when
// no listing stall holds it, through a shared key comparator, keeps the valid bits
// and builds the result words. Depends on trt_pkg and trt_in_if.
`default_nettype none

module trt_seq (
  input  logic              clk,
  input  logic              rst,
  trt_in_if.sink            req,
  output trt_pkg::ram_req_t ram,
  input  trt_pkg::entry_t   rd_entry,
  output logic              out_load,
  output trt_pkg::result_t  out_data,
  input  logic              out_free
);
  import trt_pkg::*;

  state_t state, state_next;

  // Latched request.
  logic [OPC_W-1:0]  op;
  logic [TASK_W-1:0] key_id;
  logic [SOCK_W-1:0] key_sock;
  logic [PORT_W-1:0] new_port;
  logic              new_msgs;

  logic [TABLE_SLOTS-1:0] valid_bits;

  // Scan pipeline: scan_idx is the next slot to read, d_idx the slot on the RAM output.
  logic [SCAN_W-1:0] scan_idx;
  logic              d_valid;
  logic [SLOT_W-1:0] d_idx;

  logic              hit;
  logic [SLOT_W-1:0] hit_idx;
  entry_t            hit_entry;
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  logic              pend_valid;
  result_t           pend;
  logic [CNT_W-1:0]  n;

  // Shared comparator and per-slot decisions.
  logic              id_op;
  logic [TASK_W-1:0] key_a, key_b;
  logic              key_eq;
  logic              slot_v;
  logic              hit_id, hit_sock;
  logic              last_slot;
  logic              stall, scan_done;
  logic              accept, finish_fire;
  logic [REFS_W-1:0] new_refs;
  entry_t            new_entry;
  result_t           list_res, final_res;

  assign id_op = (op == OP_REGISTER) || (op == OP_REMOVE) ||
                 (op == OP_FIND) || (op == OP_FIND_ANY);

  assign key_a  = id_op ? rd_entry.task_id : {{(TASK_W-SOCK_W){1'b0}}, rd_entry.socket};
  assign key_b  = id_op ? key_id : {{(TASK_W-SOCK_W){1'b0}}, key_sock};
  assign key_eq = (key_a == key_b);

  assign slot_v    = valid_bits[d_idx];
  assign hit_id    = d_valid && slot_v && key_eq;
  assign hit_sock  = d_valid && slot_v && !rd_entry.lost && key_eq;
  assign last_slot = (scan_idx == SCAN_W'(TABLE_SLOTS));

  assign new_refs = (hit_entry.refs != '0) ? REFS_W'(hit_entry.refs - 1'b1) : '0;

  always_comb begin
    new_entry.task_id = key_id;
    new_entry.socket  = key_sock;
    new_entry.port    = new_port;
    new_entry.lost    = 1'b0;
    new_entry.eof     = !new_msgs;
    new_entry.refs    = new_msgs ? REFS_WITH_MSGS : REFS_PLAIN;
  end

  always_comb begin
    list_res.status       = ST_OK;
    list_res.found_task   = rd_entry.task_id;
    list_res.found_socket = rd_entry.socket;
    list_res.found_port   = rd_entry.port;
    list_res.found_lost   = rd_entry.lost;
    list_res.found_eof    = rd_entry.eof;
    list_res.found_refs   = rd_entry.refs;
    list_res.match_count  = n + 1'b1;
    list_res.last         = 1'b0;
  end

  // Closing result word of the operation.
  always_comb begin
    final_res        = '0;
    final_res.status = ST_OK;
    final_res.last   = 1'b1;
    case (op)
      OP_REGISTER: begin
        if (hit) begin
          final_res.status = ST_DUP;
        end else if (free_found) begin
          final_res.found_task   = new_entry.task_id;
          final_res.found_socket = new_entry.socket;
          final_res.found_port   = new_entry.port;
          final_res.found_lost   = new_entry.lost;
          final_res.found_eof    = new_entry.eof;
          final_res.found_refs   = new_entry.refs;
        end else begin
          final_res.status = ST_FULL;
        end
      end
      OP_REMOVE, OP_FIND, OP_FIND_ANY: begin
        if (!hit) begin
          final_res.status = ST_NOT_FOUND;
        end else if ((op == OP_FIND) && hit_entry.lost) begin
          final_res.status = ST_LOST;
        end else begin
          final_res.found_task   = hit_entry.task_id;
          final_res.found_socket = hit_entry.socket;
          final_res.found_port   = hit_entry.port;
          final_res.found_lost   = hit_entry.lost;
          final_res.found_eof    = hit_entry.eof;
          final_res.found_refs   = (op == OP_REMOVE) ? new_refs : hit_entry.refs;
        end
      end
      OP_MARK_LOST: begin
        final_res.match_count = n;
      end
      OP_LIST: begin
        if (pend_valid) begin
          final_res      = pend;
          final_res.last = 1'b1;
        end
      end
      default: begin
        final_res = '0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (req.opcode inside {OP_REGISTER, OP_REMOVE, OP_FIND, OP_FIND_ANY,
                                 OP_MARK_LOST, OP_LIST}) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Outputs and datapath controls.
  always_comb begin
    req.ready   = 1'b0;
    accept      = 1'b0;
    stall       = 1'b0;
    scan_done   = 1'b0;
    finish_fire = 1'b0;
    ram         = '0;
    out_load    = 1'b0;
    out_data    = final_res;
    case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        accept    = req.valid;
      end
      S_SCAN: begin
        // A second listed match while the older one cannot leave: read the slot again.
        stall = (op == OP_LIST) && hit_sock && pend_valid && !out_free;
        scan_done = d_valid && !stall &&
                    (last_slot || (id_op && hit_id) ||
                     ((op == OP_LIST) && hit_sock && (n == CNT_W'(MAX_RESULTS - 1))));
        if (stall) begin
          ram.rd_en   = 1'b1;
          ram.rd_addr = d_idx;
        end else if (!last_slot) begin
          ram.rd_en   = 1'b1;
          ram.rd_addr = scan_idx[SLOT_W-1:0];
        end
        if ((op == OP_MARK_LOST) && hit_sock) begin
          ram.wr_en        = 1'b1;
          ram.wr_addr      = d_idx;
          ram.wr_data      = rd_entry;
          ram.wr_data.lost = 1'b1;
        end
        if ((op == OP_LIST) && hit_sock && pend_valid && out_free) begin
          out_load = 1'b1;
          out_data = pend;
        end
      end
      S_FINISH: begin
        finish_fire = out_free;
        if (out_free) begin
          out_load = (op inside {OP_REGISTER, OP_REMOVE, OP_FIND, OP_FIND_ANY,
                                 OP_MARK_LOST, OP_LIST});
          if ((op == OP_REGISTER) && !hit && free_found) begin
            ram.wr_en   = 1'b1;
            ram.wr_addr = free_idx;
            ram.wr_data = new_entry;
          end else if ((op == OP_REMOVE) && hit) begin
            ram.wr_en        = 1'b1;
            ram.wr_addr      = hit_idx;
            ram.wr_data      = hit_entry;
            ram.wr_data.refs = new_refs;
          end
        end
      end
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid_bits <= '0;
      d_valid    <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        d_valid    <= 1'b0;
        hit        <= 1'b0;
        free_found <= 1'b0;
        pend_valid <= 1'b0;
      end else if ((state == S_SCAN) && !stall) begin
        d_valid <= !last_slot;
        if (id_op && hit_id) begin
          hit <= 1'b1;
        end
        if ((op == OP_REGISTER) && d_valid && !slot_v && !free_found) begin
          free_found <= 1'b1;
        end
        if ((op == OP_LIST) && hit_sock) begin
          pend_valid <= 1'b1;
        end
      end else if (finish_fire) begin
        if ((op == OP_REGISTER) && !hit && free_found) begin
          valid_bits[free_idx] <= 1'b1;
        end else if ((op == OP_REMOVE) && hit && (new_refs == '0)) begin
          valid_bits[hit_idx] <= 1'b0;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op       <= req.opcode;
      key_id   <= req.task_id;
      key_sock <= req.socket;
      new_port <= req.port;
      new_msgs <= req.with_messages;
      scan_idx <= '0;
      n        <= '0;
    end else if ((state == S_SCAN) && !stall) begin
      if (!last_slot) begin
        d_idx    <= scan_idx[SLOT_W-1:0];
        scan_idx <= scan_idx + 1'b1;
      end
      if (id_op && hit_id) begin
        hit_idx   <= d_idx;
        hit_entry <= rd_entry;
      end
      if ((op == OP_REGISTER) && d_valid && !slot_v && !free_found) begin
        free_idx <= d_idx;
      end
      if (((op == OP_MARK_LOST) || (op == OP_LIST)) && hit_sock) begin
        n <= n + 1'b1;
      end
      if ((op == OP_LIST) && hit_sock) begin
        pend <= list_res;
      end
    end
  end

endmodule

`default_nettype wire
